>>> src/wbcf_pkg.sv
// types, constants and helpers shared by the webm block cluster framer
`default_nettype none

package wbcf_pkg;

  localparam int unsigned TRACK_W    = 2;
  localparam int unsigned LEN_W      = 32;
  localparam int unsigned TIME_W     = 64;
  localparam int unsigned MS_W       = 45;
  localparam int unsigned BYTES_W    = 48;
  localparam int unsigned SPAN_W     = 15;
  localparam int unsigned OFF_W      = 16;
  localparam int unsigned SW_W       = 4;
  localparam int unsigned FLAGS_W    = 8;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 15;

  localparam int unsigned SIZE_W = 33;
  localparam int unsigned CODE_W = 36;
  localparam int unsigned ADD_W  = 34;

  // ns to ms: shift out 2^6, then divide by 5^6 one 16-bit digit at a time
  localparam int unsigned NS_SHIFT = 6;
  localparam int unsigned DIG_W    = 16;
  localparam int unsigned NDIG     = 4;
  localparam int unsigned XP_W     = DIG_W * NDIG;
  localparam int unsigned REM_W    = 14;
  localparam int unsigned DVD_W    = REM_W + DIG_W;
  localparam int unsigned RECIP_W  = 31;
  localparam int unsigned PROD_W   = DVD_W + RECIP_W;
  localparam int unsigned RECIP_SH = 44;
  localparam logic [REM_W-1:0]   DIV_ODD = 14'd15625;
  localparam logic [RECIP_W-1:0] RECIP   = 31'd1125899907;

  localparam logic [TRACK_W-1:0] TRK_VIDEO = 2'd1;
  localparam logic [TRACK_W-1:0] TRK_SOUND = 2'd2;
  localparam logic [FLAGS_W-1:0] FLAG_KEY  = 8'h80;
  localparam logic [SIZE_W-1:0]  SIZE_HDR  = 33'd4;

  localparam logic [SIZE_W-1:0] VINT_LIM1 = 33'd127;
  localparam logic [SIZE_W-1:0] VINT_LIM2 = 33'd16383;
  localparam logic [SIZE_W-1:0] VINT_LIM3 = 33'd2097151;
  localparam logic [SIZE_W-1:0] VINT_LIM4 = 33'd268435455;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_INVALID  = 2'd1,
    ST_NO_TRACK = 2'd2
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SPAN  = 2'd0,
    CFG_SOUND = 2'd1
  } cfg_idx_e;

  typedef struct packed {
    logic [TRACK_W-1:0] track_id;
    logic [LEN_W-1:0]   payload_length;
    logic [TIME_W-1:0]  time_ns;
    logic               key_flag;
  } in_item_t;

  typedef struct packed {
    status_e             status;
    logic                start_header;
    logic                close_cluster;
    logic [BYTES_W-1:0]  closed_bytes;
    logic                open_cluster;
    logic [TIME_W-1:0]   cluster_time;
    logic                add_cue;
    logic signed [OFF_W-1:0] time_offset;
    logic [SW_W-1:0]     size_width;
    logic [TIME_W-1:0]   size_code;
    logic [FLAGS_W-1:0]  flags_byte;
    logic [TIME_W-1:0]   duration_ms;
  } out_item_t;

  typedef struct packed {
    logic [TRACK_W-1:0] track_id;
    logic               len_zero;
    logic               key_flag;
    logic [SW_W-1:0]    size_width;
    logic [CODE_W-1:0]  size_code;
    logic [ADD_W-1:0]   blk_add;
  } side_t;

  typedef struct packed {
    side_t           side;
    logic [MS_W-1:0] ms;
  } pkt_t;

  // block size varint and the bytes the block adds to the cluster body
  function automatic side_t side_enc(input in_item_t it);
    side_t             s;
    logic [SIZE_W-1:0] sz;
    logic [CODE_W-1:0] mk;
    logic [SW_W-1:0]   w;
    sz = SIZE_W'(it.payload_length) + SIZE_HDR;
    if (sz < VINT_LIM1) begin
      w  = 4'd1;
      mk = CODE_W'(1) << 7;
    end else if (sz < VINT_LIM2) begin
      w  = 4'd2;
      mk = CODE_W'(1) << 14;
    end else if (sz < VINT_LIM3) begin
      w  = 4'd3;
      mk = CODE_W'(1) << 21;
    end else if (sz < VINT_LIM4) begin
      w  = 4'd4;
      mk = CODE_W'(1) << 28;
    end else begin
      w  = 4'd5;
      mk = CODE_W'(1) << 35;
    end
    s.track_id   = it.track_id;
    s.len_zero   = (it.payload_length == '0);
    s.key_flag   = it.key_flag;
    s.size_width = w;
    s.size_code  = CODE_W'(sz) | mk;
    s.blk_add    = ADD_W'(sz) + ADD_W'(w) + ADD_W'(1);
    return s;
  endfunction

endpackage

`default_nettype wire

>>> src/wbcf_stream_if.sv
// valid/ready stream channel carrying one payload struct per beat
`default_nettype none

interface wbcf_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> src/webm_block_cluster_framer.sv
// top level of the webm block cluster framer
`default_nettype none

// Takes one packet descriptor per beat and returns one framing result per
// beat, in order. A descriptor can be accepted on every clock cycle while
// the output is not stalled; the beat passes the nine registers of the
// ns-to-ms divider (an input register loaded at the accepting edge, then a
// multiply stage and a remainder stage for each of four 16-bit quotient
// digits), and the cluster state logic works on the last of them, updating
// the cluster and track state and loading the result register when it
// takes the beat, ten registers in all. Stalls on the output back up
// through the divider stages, so descriptors keep being taken while the
// pipeline has empty stages.
// Configuration writes take effect on the next cycle and belong only
// between packets; there is no start-up sweep after reset.
module webm_block_cluster_framer (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [wbcf_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [wbcf_pkg::CFG_DATA_W-1:0] cfg_data_i,
  wbcf_stream_if.sink                     pkt_i,
  wbcf_stream_if.source                   res_o
);
  import wbcf_pkg::*;

  logic      div_valid;
  logic      core_ready;
  pkt_t      div_pkt;
  logic      res_valid;
  out_item_t res_data;

  wbcf_ms_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (pkt_i.valid),
    .in_ready_o  (pkt_i.ready),
    .in_data_i   (pkt_i.data),
    .out_valid_o (div_valid),
    .out_ready_i (core_ready),
    .out_pkt_o   (div_pkt)
  );

  wbcf_frame_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .pkt_valid_i (div_valid),
    .pkt_ready_o (core_ready),
    .pkt_i       (div_pkt),
    .res_valid_o (res_valid),
    .res_ready_i (res_o.ready),
    .res_o       (res_data)
  );

  assign res_o.valid = res_valid;
  assign res_o.data  = res_data;

`ifndef SYNTHESIS
  a_core_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_valid && core_ready |=> res_valid)
    else $error("taken beat did not reach the result register");

  a_close_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && (res_data.close_cluster || res_data.add_cue) |-> res_data.open_cluster)
    else $error("cluster closed or cue added without opening a cluster");

  a_err_no_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && res_data.status != ST_OK |->
      res_data.size_width == '0 && res_data.flags_byte == '0 && res_data.size_code == '0)
    else $error("block fields set on a refused packet");
`endif

endmodule

`default_nettype wire

>>> src/wbcf_ms_div.sv
// pipelined nanosecond to millisecond divider with block size encoding
`default_nettype none

module wbcf_ms_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  wbcf_pkg::in_item_t in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output wbcf_pkg::pkt_t     out_pkt_o
);
  import wbcf_pkg::*;

  localparam int unsigned NST = 1 + 2 * NDIG;

  logic [NST-1:0] vld_q;
  logic [NST-1:0] go;
  logic [NST:0]   space;

  side_t            side_q [NST];
  logic [XP_W-1:0]  x_q    [NST];
  logic [XP_W-1:0]  quo_q  [NST];
  logic [DVD_W-1:0] dvd_q  [NDIG];
  logic [PROD_W-1:0] prod_q [NDIG];
  logic [REM_W-1:0] rem_q  [NDIG];

  logic [DVD_W-1:0] dvd_d [NDIG];
  logic [DIG_W-1:0] qd    [NDIG];
  logic [REM_W-1:0] rem_d [NDIG];

  // a stage takes a new beat when empty or when its own beat moves on
  always_comb begin
    space[NST] = out_ready_i;
    for (int i = NST - 1; i >= 0; i--) begin
      go[i]    = vld_q[i] & space[i+1];
      space[i] = ~vld_q[i] | go[i];
    end
  end

  always_comb begin
    for (int k = 0; k < NDIG; k++) begin
      if (k == 0) begin
        dvd_d[k] = {REM_W'(0), x_q[2*k][XP_W-1-DIG_W*k -: DIG_W]};
      end else begin
        dvd_d[k] = {rem_q[k-1], x_q[2*k][XP_W-1-DIG_W*k -: DIG_W]};
      end
      qd[k]    = prod_q[k][RECIP_SH +: DIG_W];
      rem_d[k] = REM_W'(dvd_q[k] - DVD_W'(qd[k]) * DVD_W'(DIV_ODD));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (space[0]) begin
        vld_q[0] <= in_valid_i;
      end
      for (int i = 1; i < NST; i++) begin
        if (space[i]) begin
          vld_q[i] <= go[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (space[0]) begin
      side_q[0] <= side_enc(in_data_i);
      x_q[0]    <= XP_W'(in_data_i.time_ns >> NS_SHIFT);
      quo_q[0]  <= '0;
    end
    for (int k = 0; k < NDIG; k++) begin
      // reciprocal multiply for one quotient digit
      if (space[2*k+1]) begin
        side_q[2*k+1] <= side_q[2*k];
        x_q[2*k+1]    <= x_q[2*k];
        quo_q[2*k+1]  <= quo_q[2*k];
        dvd_q[k]      <= dvd_d[k];
        prod_q[k]     <= PROD_W'(dvd_d[k]) * PROD_W'(RECIP);
      end
      // digit out, remainder back
      if (space[2*k+2]) begin
        side_q[2*k+2] <= side_q[2*k+1];
        x_q[2*k+2]    <= x_q[2*k+1];
        quo_q[2*k+2]  <= {quo_q[2*k+1][XP_W-DIG_W-1:0], qd[k]};
        rem_q[k]      <= rem_d[k];
      end
    end
  end

  assign in_ready_o     = space[0];
  assign out_valid_o    = vld_q[NST-1];
  assign out_pkt_o.side = side_q[NST-1];
  assign out_pkt_o.ms   = quo_q[NST-1][MS_W-1:0];

endmodule

`default_nettype wire

>>> src/wbcf_frame_core.sv
// cluster state, per-track time checks and the registered result beat
`default_nettype none

module wbcf_frame_core (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [wbcf_pkg::CFG_IDX_W-1:0]         cfg_idx_i,
  input  logic [wbcf_pkg::CFG_DATA_W-1:0]        cfg_data_i,
  input  logic                                   pkt_valid_i,
  output logic                                   pkt_ready_o,
  input  wbcf_pkg::pkt_t                         pkt_i,
  output logic                                   res_valid_o,
  input  logic                                   res_ready_i,
  output wbcf_pkg::out_item_t                    res_o
);
  import wbcf_pkg::*;

  logic [SPAN_W-1:0]  span_q;
  logic               sound_q;
  logic               hdr_q, hdr_d;
  logic               open_q, open_d;
  logic [MS_W-1:0]    start_q, start_d;
  logic [BYTES_W-1:0] bytes_q, bytes_d;
  logic [MS_W-1:0]    last_q [2];
  logic [MS_W-1:0]    last_d [2];
  logic [1:0]         seen_q, seen_d;
  logic [MS_W-1:0]    longest_q, longest_d;

  logic      res_valid_q;
  out_item_t res_q, res_d;
  logic      take;

  logic               tix;
  logic               video;
  logic               keyv;
  logic               back;
  logic [MS_W:0]      sub;
  logic               span_over;
  logic               close_c;
  logic               do_open;
  logic               in_range;
  logic [BYTES_W-1:0] base;
  logic [BYTES_W:0]   sum;

  assign pkt_ready_o = ~res_valid_q | res_ready_i;
  assign take        = pkt_valid_i & pkt_ready_o;

  always_comb begin
    tix       = (pkt_i.side.track_id == TRK_SOUND);
    video     = (pkt_i.side.track_id == TRK_VIDEO);
    keyv      = video & pkt_i.side.key_flag;
    back      = seen_q[tix] & (pkt_i.ms < last_q[tix]);
    sub       = {1'b0, pkt_i.ms} - {1'b0, start_q};
    span_over = ~sub[MS_W] & (sub >= (MS_W+1)'(span_q));
    close_c   = open_q & (keyv | span_over);
    do_open   = ~open_q | close_c;
    // signed difference fits 16 bits when its upper bits are all equal
    in_range  = do_open | (&sub[MS_W:OFF_W-1]) | ~(|sub[MS_W:OFF_W-1]);
    base      = close_c ? '0 : bytes_q;
    sum       = {1'b0, base} + (BYTES_W+1)'(pkt_i.side.blk_add);

    hdr_d     = hdr_q;
    open_d    = open_q;
    start_d   = start_q;
    bytes_d   = bytes_q;
    last_d    = last_q;
    seen_d    = seen_q;
    longest_d = longest_q;

    res_d              = '0;
    res_d.status       = ST_OK;
    res_d.cluster_time = TIME_W'(start_q);
    res_d.duration_ms  = TIME_W'(longest_q);

    if (pkt_i.side.track_id != TRK_VIDEO && pkt_i.side.track_id != TRK_SOUND) begin
      res_d.status = ST_INVALID;
    end else if (pkt_i.side.track_id == TRK_SOUND && !sound_q) begin
      res_d.status = ST_NO_TRACK;
    end else if (pkt_i.side.len_zero) begin
      res_d.status = ST_INVALID;
    end else begin
      if (!hdr_q) begin
        hdr_d              = 1'b1;
        res_d.start_header = 1'b1;
      end
      if (back) begin
        res_d.status = ST_INVALID;
      end else begin
        if (close_c) begin
          res_d.close_cluster = (bytes_q != '0);
          res_d.closed_bytes  = bytes_q;
          bytes_d             = '0;
        end
        if (do_open) begin
          start_d            = pkt_i.ms;
          open_d             = 1'b1;
          res_d.open_cluster = 1'b1;
          res_d.add_cue      = keyv;
        end
        res_d.cluster_time = TIME_W'(start_d);
        if (!in_range) begin
          res_d.status = ST_INVALID;
        end else begin
          res_d.time_offset = do_open ? '0 : $signed(sub[OFF_W-1:0]);
          res_d.size_width  = pkt_i.side.size_width;
          res_d.size_code   = TIME_W'(pkt_i.side.size_code);
          res_d.flags_byte  = (pkt_i.side.key_flag | ~video) ? FLAG_KEY : '0;
          bytes_d           = sum[BYTES_W] ? '1 : sum[BYTES_W-1:0];
          last_d[tix]       = pkt_i.ms;
          seen_d[tix]       = 1'b1;
          if (pkt_i.ms > longest_q) begin
            longest_d = pkt_i.ms;
          end
          res_d.duration_ms = TIME_W'(longest_d);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      span_q      <= SPAN_W'(1000);
      sound_q     <= 1'b0;
      hdr_q       <= 1'b0;
      open_q      <= 1'b0;
      start_q     <= '0;
      bytes_q     <= '0;
      last_q[0]   <= '0;
      last_q[1]   <= '0;
      seen_q      <= '0;
      longest_q   <= '0;
      res_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_SPAN:  span_q  <= cfg_data_i;
          CFG_SOUND: sound_q <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (take) begin
        hdr_q     <= hdr_d;
        open_q    <= open_d;
        start_q   <= start_d;
        bytes_q   <= bytes_d;
        last_q    <= last_d;
        seen_q    <= seen_d;
        longest_q <= longest_d;
      end
      if (take) begin
        res_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      res_q <= res_d;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire
